[hw/rtl/crcs_pkg.sv]
// Package for the Catmull-Rom curve sampler: widths, payload structs and
// the control structs passed between the sequencer, the lanes and the merge stage.
// No dependencies.
package crcs_pkg;

  // Coordinate format and step range.
  localparam int CoordWidth = 16;
  localparam int MaxSteps   = 31;
  localparam int CfgWidth   = 5;
  localparam logic [CfgWidth-1:0] StepsReset = CfgWidth'(20);

  // Step counter and its powers.
  localparam int SW  = $clog2(MaxSteps + 1);
  localparam int S2W = 2 * SW;
  localparam int S3W = 3 * SW;

  // Polynomial coefficients a, b, c are bounded by 12 times a coordinate.
  localparam int CoefW = CoordWidth + 4;

  // Horner pipeline widths.
  localparam int PA  = CoefW + S2W + 1;  // a * s^2
  localparam int PW1 = CoefW + SW + 1;   // b * s and c * k
  localparam int PW2 = PW1 + 1;          // b * s + c * k
  localparam int PW3 = PW2 + SW + 1;     // (b * s + c * k) * k
  localparam int PW4 = PW3 + 1;          // a * s^2 + previous
  localparam int PW5 = PW4 + SW + 1;     // numerator R

  // Divider: the divisor is 2 * s^3, the quotient is offset to stay positive.
  localparam int DW          = S3W + 1;
  localparam int QW          = CoordWidth + 4;
  localparam int NW          = S3W + CoordWidth + 5;
  localparam int OffsetShift = CoordWidth + 3;

  // Final sum width before saturation.
  localparam int VW = QW + 2;

  // Cycles from a sample index entering a lane to its value leaving it.
  localparam int LaneLat = QW + 7;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } point_t;

  typedef struct packed {
    coord_t sample_x;
    coord_t sample_y;
    logic   segment_end;
    logic   last_of_run;
  } sample_t;

  // The four control points of one coordinate for the current segment.
  typedef struct packed {
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
  } lane_pts_t;

  typedef struct packed {
    logic          setup1;
    logic          setup2;
    logic [SW-1:0] k;
    logic [SW-1:0] steps;
  } lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic segment_end;
    logic last_of_run;
  } tag_t;

endpackage

[hw/rtl/crcs_div.sv]
// Pipelined restoring divider for the curve sampler lanes, one quotient bit per stage.
// Depends on crcs_pkg.
module crcs_div import crcs_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int Bit = QW - 1 - j;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = NW'(den_in) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          quo_q[j] <= quo_in | (QW'(1) << Bit);
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

[hw/rtl/crcs_lane.sv]
// One coordinate lane of the curve sampler: per-segment coefficients, a Horner
// pipeline over the sample index, the rounding divide and saturation.
// Depends on crcs_pkg and crcs_div.
module crcs_lane import crcs_pkg::*; (
  input  logic      clk_i,
  input  logic      adv_i,
  input  lane_ctl_t ctl_i,
  input  lane_pts_t pts_i,
  output coord_t    value_o
);

  localparam logic signed [VW-1:0] OffsetV = VW'(1) << OffsetShift;
  localparam logic signed [VW-1:0] SatMax =
      {{(VW-CoordWidth+1){1'b0}}, {(CoordWidth-1){1'b1}}};
  localparam logic signed [VW-1:0] SatMin =
      {{(VW-CoordWidth+1){1'b1}}, {(CoordWidth-1){1'b0}}};

  logic signed [CoefW-1:0] e0, e1, e2, e3;
  logic signed [CoefW-1:0] a_q, b_q, c_q;
  coord_t                  p1_q;
  logic [S2W-1:0]          s2_q;
  logic [S3W-1:0]          s3_q;
  logic signed [PA-1:0]    a2_q;
  logic signed [PW1-1:0]   b1_q;

  // Pipeline stages, numbered by the stage that produced them.
  logic signed [PW1-1:0] ck_1_q, b1_1_q;
  logic signed [PA-1:0]  a2_1_q, a2_2_q, a2_3_q;
  logic [SW-1:0]         k_1_q, k_2_q, k_3_q, k_4_q;
  logic [S3W-1:0]        s3_1_q, s3_2_q, s3_3_q, s3_4_q, s3_5_q;
  coord_t                p1_1_q, p1_2_q, p1_3_q, p1_4_q, p1_5_q, p1_6_q;
  logic signed [PW2-1:0] t1_2_q;
  logic signed [PW3-1:0] m_3_q;
  logic signed [PW4-1:0] t2_4_q;
  logic signed [PW5-1:0] r_5_q;
  logic [NW-1:0]         n_6_q;
  logic [DW-1:0]         d_6_q;

  logic [DW-1:0]         dv;
  logic signed [PW5:0]   nsum;
  coord_t                p1_dq [QW];
  logic [QW-1:0]         quo;
  logic signed [VW-1:0]  v;
  coord_t                value_q;

  always_comb begin
    e0 = CoefW'(pts_i.p0);
    e1 = CoefW'(pts_i.p1);
    e2 = CoefW'(pts_i.p2);
    e3 = CoefW'(pts_i.p3);
  end

  // Segment setup: a = p2 - p0, b = 2p0 - 5p1 + 4p2 - p3, c = -p0 + 3p1 - 3p2 + p3,
  // then the products with s and s^2 on the following cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.setup1) begin
      a_q  <= e2 - e0;
      b_q  <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c_q  <= e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
      p1_q <= pts_i.p1;
      s2_q <= S2W'(ctl_i.steps) * S2W'(ctl_i.steps);
    end
    if (ctl_i.setup2) begin
      a2_q <= a_q * $signed({1'b0, s2_q});
      b1_q <= b_q * $signed({1'b0, ctl_i.steps});
      s3_q <= s2_q * S3W'(ctl_i.steps);
    end
  end

  // The offset numerator R + s^3 + 2s^3 * 2^OffsetShift is never negative.
  assign dv   = {s3_5_q, 1'b0};
  assign nsum = (PW5+1)'(r_5_q) + $signed((PW5+1)'(s3_5_q))
              + $signed((PW5+1)'(dv) << OffsetShift);

  // R = k * (a s^2 + k * (b s + c k)); multiplies in stages 1, 3 and 5, adds in stages 2 and 4.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ck_1_q <= c_q * $signed({1'b0, ctl_i.k});
      b1_1_q <= b1_q;
      a2_1_q <= a2_q;
      k_1_q  <= ctl_i.k;
      s3_1_q <= s3_q;
      p1_1_q <= p1_q;

      t1_2_q <= PW2'(b1_1_q) + PW2'(ck_1_q);
      a2_2_q <= a2_1_q;
      k_2_q  <= k_1_q;
      s3_2_q <= s3_1_q;
      p1_2_q <= p1_1_q;

      m_3_q  <= t1_2_q * $signed({1'b0, k_2_q});
      a2_3_q <= a2_2_q;
      k_3_q  <= k_2_q;
      s3_3_q <= s3_2_q;
      p1_3_q <= p1_2_q;

      t2_4_q <= PW4'(a2_3_q) + PW4'(m_3_q);
      k_4_q  <= k_3_q;
      s3_4_q <= s3_3_q;
      p1_4_q <= p1_3_q;

      r_5_q  <= t2_4_q * $signed({1'b0, k_4_q});
      s3_5_q <= s3_4_q;
      p1_5_q <= p1_4_q;

      n_6_q  <= nsum[NW-1:0];
      d_6_q  <= dv;
      p1_6_q <= p1_5_q;
    end
  end

  crcs_div u_div (
    .clk_i (clk_i),
    .en_i  (adv_i),
    .num_i (n_6_q),
    .den_i (d_6_q),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_dq[0] <= p1_6_q;
      for (int i = 1; i < QW; i++) begin
        p1_dq[i] <= p1_dq[i-1];
      end
    end
  end

  assign v = VW'(p1_dq[QW-1]) + $signed({2'b00, quo}) - OffsetV;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (v > SatMax) begin
        value_q <= CoordWidth'(SatMax);
      end else if (v < SatMin) begin
        value_q <= CoordWidth'(SatMin);
      end else begin
        value_q <= CoordWidth'(v);
      end
    end
  end

  assign value_o = value_q;

endmodule

[hw/rtl/crcs_ctrl.sv]
// Sequencer of the curve sampler: configuration register, point history,
// segment selection and the sample index counter.
// Depends on crcs_pkg.
module crcs_ctrl import crcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  point_t              in_data_i,
  input  logic                adv_i,
  output lane_pts_t           pts_x_o,
  output lane_pts_t           pts_y_o,
  output lane_ctl_t           ctl_o,
  output tag_t                tag_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSetup1 = 2'd1;
  localparam logic [1:0] StSetup2 = 2'd2;
  localparam logic [1:0] StRun    = 2'd3;

  localparam logic SelMid = 1'b0;  // segment between the two older points
  localparam logic SelEnd = 1'b1;  // closing segment up to the last point

  logic [1:0]          state_q, state_d;
  logic [CfgWidth-1:0] steps_q;
  coord_t              hist_x_q [3];
  coord_t              hist_y_q [3];
  coord_t              hist_x_d [3];
  coord_t              hist_y_d [3];
  logic [1:0]          seen_q, seen_d;
  point_t              np_q, np_d, src;
  logic                pend_end_q, pend_end_d;
  logic                sel_q, sel_d;
  logic [SW-1:0]       k_q, k_d;
  logic [SW-1:0]       s_eff;
  logic                commit;
  logic                k_last;

  always_comb begin
    if (steps_q == '0) begin
      s_eff = SW'(1);
    end else if (int'(steps_q) > MaxSteps) begin
      s_eff = SW'(MaxSteps);
    end else begin
      s_eff = SW'(steps_q);
    end
  end

  assign k_last     = (k_q == s_eff);
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    np_d       = np_q;
    pend_end_d = pend_end_q;
    sel_d      = sel_q;
    k_d        = k_q;
    commit     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          np_d = in_data_i;
          if (seen_q >= 2'd2) begin
            sel_d      = SelMid;
            pend_end_d = in_data_i.last_point;
            state_d    = StSetup1;
          end else if (in_data_i.last_point && seen_q >= 2'd1) begin
            sel_d      = SelEnd;
            pend_end_d = 1'b0;
            state_d    = StSetup1;
          end else begin
            commit = 1'b1;
          end
        end
      end
      StSetup1: begin
        state_d = StSetup2;
      end
      StSetup2: begin
        k_d     = '0;
        state_d = StRun;
      end
      StRun: begin
        if (adv_i) begin
          if (k_last) begin
            if (pend_end_q) begin
              sel_d      = SelEnd;
              pend_end_d = 1'b0;
              state_d    = StSetup1;
            end else begin
              commit  = 1'b1;
              state_d = StIdle;
            end
          end else begin
            k_d = k_q + SW'(1);
          end
        end
      end
    endcase
  end

  // History update once a transaction has produced all of its samples.
  assign src = (state_q == StIdle) ? in_data_i : np_q;

  always_comb begin
    hist_x_d = hist_x_q;
    hist_y_d = hist_y_q;
    seen_d   = seen_q;
    if (commit) begin
      if (src.last_point) begin
        for (int i = 0; i < 3; i++) begin
          hist_x_d[i] = '0;
          hist_y_d[i] = '0;
        end
        seen_d = '0;
      end else begin
        hist_x_d[0] = hist_x_q[1];
        hist_y_d[0] = hist_y_q[1];
        hist_x_d[1] = hist_x_q[2];
        hist_y_d[1] = hist_y_q[2];
        hist_x_d[2] = src.point_x;
        hist_y_d[2] = src.point_y;
        seen_d      = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      steps_q    <= StepsReset;
      seen_q     <= '0;
      pend_end_q <= 1'b0;
      sel_q      <= SelMid;
      k_q        <= '0;
      for (int i = 0; i < 3; i++) begin
        hist_x_q[i] <= '0;
        hist_y_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      seen_q     <= seen_d;
      pend_end_q <= pend_end_d;
      sel_q      <= sel_d;
      k_q        <= k_d;
      hist_x_q   <= hist_x_d;
      hist_y_q   <= hist_y_d;
      if (cfg_we_i) begin
        steps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    np_q <= np_d;
  end

  // On a fresh stream the missing outer points are copies of the inner ones.
  always_comb begin
    if (sel_q == SelMid) begin
      pts_x_o.p0 = (seen_q == 2'd3) ? hist_x_q[0] : hist_x_q[1];
      pts_y_o.p0 = (seen_q == 2'd3) ? hist_y_q[0] : hist_y_q[1];
      pts_x_o.p1 = hist_x_q[1];
      pts_y_o.p1 = hist_y_q[1];
      pts_x_o.p2 = hist_x_q[2];
      pts_y_o.p2 = hist_y_q[2];
    end else begin
      pts_x_o.p0 = (seen_q >= 2'd2) ? hist_x_q[1] : hist_x_q[2];
      pts_y_o.p0 = (seen_q >= 2'd2) ? hist_y_q[1] : hist_y_q[2];
      pts_x_o.p1 = hist_x_q[2];
      pts_y_o.p1 = hist_y_q[2];
      pts_x_o.p2 = np_q.point_x;
      pts_y_o.p2 = np_q.point_y;
    end
    pts_x_o.p3 = np_q.point_x;
    pts_y_o.p3 = np_q.point_y;
  end

  assign ctl_o.setup1 = (state_q == StSetup1);
  assign ctl_o.setup2 = (state_q == StSetup2);
  assign ctl_o.k      = k_q;
  assign ctl_o.steps  = s_eff;

  assign tag_o.valid       = (state_q == StRun);
  assign tag_o.segment_end = k_last;
  assign tag_o.last_of_run = k_last && !pend_end_q;

endmodule

[hw/rtl/crcs_merge.sv]
// Merge stage of the curve sampler: delays the sample flags alongside the lanes,
// joins them with the x and y values and holds the output register.
// Depends on crcs_pkg.
module crcs_merge import crcs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tag_t    tag_i,
  input  coord_t  x_i,
  input  coord_t  y_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output sample_t out_data_o,
  output logic    adv_o
);

  tag_t    tag_q [LaneLat];
  logic    out_valid_q;
  sample_t out_data_q;
  logic    adv;

  // The whole sample pipeline moves only when the output register can take a result.
  assign adv = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LaneLat; i++) begin
        tag_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < LaneLat; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      out_valid_q <= tag_q[LaneLat-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.sample_x    <= x_i;
      out_data_q.sample_y    <= y_i;
      out_data_q.segment_end <= tag_q[LaneLat-1].segment_end;
      out_data_q.last_of_run <= tag_q[LaneLat-1].last_of_run;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign adv_o       = adv;

endmodule

[hw/rtl/catmull_rom_curve_sampler.sv]
// Uniform Catmull-Rom curve sampler. Control points arrive one transaction at a
// time; each segment gives steps_per_segment + 1 samples at t = k/steps, rounded
// and saturated, issued one per cycle while the output is not stalled. A point that
// closes one segment passes through the accepting state, the two setup states for
// the segment coefficients, then one run step per sample; the last point of a stream
// with at least three points closes two segments and goes through the setup and run
// states twice; a point that closes none is taken in the accepting state alone. The
// sequencer handles one point at a time. Each sample passes through the x and y lanes
// (multiply pipeline, a 20-stage divider and the saturation register) and then the
// merge stage's output register; while the output is stalled the whole sample pipeline holds.
// Depends on crcs_pkg, crcs_ctrl, crcs_lane, crcs_div and crcs_merge.
module catmull_rom_curve_sampler import crcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  point_t              in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sample_t             out_data_o
);

  lane_pts_t pts_x, pts_y;
  lane_ctl_t ctl;
  tag_t      tag;
  logic      adv;
  coord_t    x_val, y_val;

  crcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .adv_i       (adv),
    .pts_x_o     (pts_x),
    .pts_y_o     (pts_y),
    .ctl_o       (ctl),
    .tag_o       (tag)
  );

  crcs_lane u_lane_x (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .ctl_i   (ctl),
    .pts_i   (pts_x),
    .value_o (x_val)
  );

  crcs_lane u_lane_y (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .ctl_i   (ctl),
    .pts_i   (pts_y),
    .value_o (y_val)
  );

  crcs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .x_i         (x_val),
    .y_i         (y_val),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .adv_o       (adv)
  );

endmodule

[test/crcs_sample_checker.sv]
`timescale 1ns / 100ps
// Sample checker for the Catmull-Rom curve sampler: follows the configuration
// port and the point channel, predicts every sample and compares the sample channel.
// Depends on crcs_pkg.
module crcs_sample_checker import crcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  point_t              in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sample_t             out_data_i,
  output int                  mismatch_count_o,
  output int                  samples_pending_o,
  output int                  samples_checked_o
);

  localparam longint CoordHi    = (longint'(1) <<< (CoordWidth - 1)) - 1;
  localparam longint CoordLo    = -CoordHi - 1;
  localparam int     MaxReports = 100;

  logic [CfgWidth-1:0] steps_q;
  coord_t              hist_x [3];
  coord_t              hist_y [3];
  int unsigned         points_held;
  sample_t             expected_samples [$];
  int                  mismatches;
  int                  checked;

  assign mismatch_count_o  = mismatches;
  assign samples_pending_o = expected_samples.size();
  assign samples_checked_o = checked;

  // Spline value at t = k/s, rounded half up and saturated to the coordinate range.
  function automatic coord_t spline_value(longint p0, longint p1, longint p2, longint p3,
                                          longint k, longint s);
    longint a, b, c, s3, num, den, q;
    a   = p2 - p0;
    b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c   = -p0 + 3 * p1 - 3 * p2 + p3;
    s3  = s * s * s;
    num = 2 * p1 * s3 + a * k * s * s + b * k * k * s + c * k * k * k;
    den = 2 * s3;
    // The divisor is positive, so only a negative dividend needs the floor fix.
    q = (2 * num + den) / (2 * den);
    if (((2 * num + den) % (2 * den)) != 0 && (2 * num + den) < 0) q -= 1;
    if (q > CoordHi) q = CoordHi;
    if (q < CoordLo) q = CoordLo;
    return coord_t'(q);
  endfunction

  function automatic void queue_segment(lane_pts_t xs, lane_pts_t ys, int s);
    sample_t smp;
    for (int k = 0; k <= s; k++) begin
      smp.sample_x    = spline_value(xs.p0, xs.p1, xs.p2, xs.p3, k, s);
      smp.sample_y    = spline_value(ys.p0, ys.p1, ys.p2, ys.p3, k, s);
      smp.segment_end = (k == s);
      smp.last_of_run = 1'b0;
      expected_samples.push_back(smp);
    end
  endfunction

  function automatic void predict_point(point_t pt);
    int          s;
    int unsigned held;
    int          queued_at_entry;
    lane_pts_t   xs;
    lane_pts_t   ys;
    sample_t     tail;
    s      = (steps_q == 0) ? 1 : int'(steps_q);
    if (s > MaxSteps) s = MaxSteps;
    held   = points_held;
    queued_at_entry = expected_samples.size();

    // A new point closes the segment between the two previous points.
    if (held >= 2) begin
      xs.p0 = (held >= 3) ? hist_x[0] : hist_x[1];
      ys.p0 = (held >= 3) ? hist_y[0] : hist_y[1];
      xs.p1 = hist_x[1];
      ys.p1 = hist_y[1];
      xs.p2 = hist_x[2];
      ys.p2 = hist_y[2];
      xs.p3 = pt.point_x;
      ys.p3 = pt.point_y;
      queue_segment(xs, ys, s);
    end
    // The last point also closes the final segment, with itself doubled as p3.
    if (pt.last_point && held >= 1) begin
      xs.p0 = (held >= 2) ? hist_x[1] : hist_x[2];
      ys.p0 = (held >= 2) ? hist_y[1] : hist_y[2];
      xs.p1 = hist_x[2];
      ys.p1 = hist_y[2];
      xs.p2 = pt.point_x;
      ys.p2 = pt.point_y;
      xs.p3 = pt.point_x;
      ys.p3 = pt.point_y;
      queue_segment(xs, ys, s);
    end
    if (expected_samples.size() > queued_at_entry) begin
      tail = expected_samples.pop_back();
      tail.last_of_run = 1'b1;
      expected_samples.push_back(tail);
    end

    if (pt.last_point) begin
      for (int i = 0; i < 3; i++) begin
        hist_x[i] = '0;
        hist_y[i] = '0;
      end
      points_held = 0;
    end else begin
      hist_x[0] = hist_x[1];
      hist_y[0] = hist_y[1];
      hist_x[1] = hist_x[2];
      hist_y[1] = hist_y[2];
      hist_x[2] = pt.point_x;
      hist_y[2] = pt.point_y;
      points_held = (held >= 3) ? 3 : held + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      steps_q     = StepsReset;
      points_held = 0;
      mismatches  = 0;
      checked     = 0;
      expected_samples.delete();
      for (int i = 0; i < 3; i++) begin
        hist_x[i] = '0;
        hist_y[i] = '0;
      end
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: unexpected sample x=%0d y=%0d end=%0b last=%0b", $time,
                     out_data_i.sample_x, out_data_i.sample_y,
                     out_data_i.segment_end, out_data_i.last_of_run);
          end
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (out_data_i.sample_x !== want.sample_x || out_data_i.sample_y !== want.sample_y ||
              out_data_i.segment_end !== want.segment_end ||
              out_data_i.last_of_run !== want.last_of_run) begin
            mismatches++;
            // Only the first reports are printed; later ones are counted.
            if (mismatches <= MaxReports) begin
              $display("%0t: sample mismatch: expected x=%0d y=%0d end=%0b last=%0b, got x=%0d y=%0d end=%0b last=%0b",
                       $time, want.sample_x, want.sample_y, want.segment_end,
                       want.last_of_run, out_data_i.sample_x, out_data_i.sample_y,
                       out_data_i.segment_end, out_data_i.last_of_run);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_point(in_data_i);
      if (cfg_we_i) steps_q = cfg_wdata_i;
    end
  end

endmodule

[test/tb_catmull_rom_curve_sampler.sv]
`timescale 1ns / 100ps
// Testbench top for the Catmull-Rom curve sampler: clock, reset, point streams,
// step settings and output stalls; the verdict comes from crcs_sample_checker.
// Depends on crcs_pkg, crcs_sample_checker and catmull_rom_curve_sampler.
module tb_catmull_rom_curve_sampler import crcs_pkg::*; ;

  localparam int     CycleLimit   = 600000;
  localparam int     SettleCycles = 64;
  localparam int     RandomPhases = 5;
  localparam int     PhasePoints  = 60;
  localparam coord_t CoordMax     = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam coord_t CoordMin     = {1'b1, {(CoordWidth - 1){1'b0}}};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgWidth-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  point_t              in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  sample_t             out_data_o;

  int          mismatch_count;
  int          samples_pending;
  int          samples_checked;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  int          points_sent = 0;
  int          streams_sent = 0;
  int          settings_used = 1;

  catmull_rom_curve_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  crcs_sample_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_data_i         (in_data_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_i        (out_data_o),
    .mismatch_count_o  (mismatch_count),
    .samples_pending_o (samples_pending),
    .samples_checked_o (samples_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("%0t: cycle limit reached with %0d samples outstanding", $time, samples_pending);
    $display("** catmull_rom_curve_sampler: FAILED **");
    $finish;
  end

  // Sample sink: before each transaction it holds ready low for a random number of cycles, none while calm.
  initial begin : sample_sink
    int gap;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return CoordMax;
      1:       return CoordMin;
      2:       return '0;
      3:       return coord_t'(int'($urandom_range(0, 63)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Called and returns at a falling edge.
  task automatic send_point(input coord_t x, input coord_t y, input logic last_pt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{point_x: x, point_y: y, last_point: last_pt};
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    points_sent++;
    if (last_pt) streams_sent++;
    @(negedge clk_i);
  endtask

  // Waits for the block to drain, including points that produce no samples.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (samples_pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_steps(input logic [CfgWidth-1:0] steps);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= steps;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int   phase_points;
    int   len;
    logic last_pt;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting of 20 steps. A lone point marked last produces nothing.
    send_point(CoordMax, CoordMin, 1'b1);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(CoordMin, CoordMax, 1'b1);
    // Repeated extreme points flanked by zeros make the spline overshoot and saturate.
    send_point('0, '0, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point('0, '0, 1'b0);
    send_point(CoordMin, CoordMax, 1'b1);

    // A step count of zero behaves as one.
    set_steps('0);
    send_point(coord_t'(16), coord_t'(-16), 1'b0);
    send_point(coord_t'(-1), coord_t'(1), 1'b0);
    send_point(coord_t'(1), coord_t'(-1), 1'b1);

    set_steps(CfgWidth'(MaxSteps));
    send_point(coord_t'(1), coord_t'(0), 1'b0);
    send_point(coord_t'(2), coord_t'(-3), 1'b0);
    send_point(coord_t'(-5), coord_t'(7), 1'b0);
    send_point(coord_t'(3), coord_t'(-1), 1'b1);

    set_steps(CfgWidth'(1));
    send_point(coord_t'(-1), coord_t'(3), 1'b0);
    send_point(CoordMax, CoordMax, 1'b1);

    // Random streams; now and then the last flag is flipped so that a stream
    // ends early or runs on into the next one.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      set_steps(CfgWidth'($urandom_range(0, MaxSteps)));
      calm         = ($urandom_range(0, 3) == 0);
      phase_points = 0;
      while (phase_points < PhasePoints) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          last_pt = (i == len - 1);
          if ($urandom_range(0, 9) == 0) last_pt = ~last_pt;
          send_point(rand_coord(), rand_coord(), last_pt);
        end
        phase_points += len;
      end
    end

    calm = 1'b0;
    drain();
    $display("Sent %0d points in %0d closed streams over %0d step settings (0, 1, 20, 31 and random).",
             points_sent, streams_sent, settings_used);
    $display("Checked %0d samples, %0d mismatches.", samples_checked, mismatch_count);
    if (mismatch_count == 0 && samples_pending == 0) begin
      $display("** catmull_rom_curve_sampler: PASSED **");
    end else begin
      $display("** catmull_rom_curve_sampler: FAILED **");
    end
    $finish;
  end

endmodule
